FILE: hdl/lzd_pkg.sv
// Shared types and constants of the LZ77 token stream decompressor.
// No dependencies; imported by lzd_packer and the top level.
package lzd_pkg;

   localparam int WINDOW_DEPTH_DEF = 32768;
   localparam int LANES_DEF        = 8;
   localparam int MATCH_TOKEN_BITS = 24;
   localparam int DIST_BITS        = 15;
   localparam int RUN_BITS         = 5;
   localparam int MIN_MATCH        = 3;
   localparam int LANE_PORTS       = 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_COPY,
      ST_FLUSH
   } lzd_state_type;

   // Packer commands: push one decoded byte, or close the item.
   typedef struct packed {
      logic       push;
      logic       flush;
      logic [7:0] data;
   } lzd_pack_req_type;

   typedef struct packed {
      logic can_push;
      logic out_free;
      logic empty;
   } lzd_pack_st_type;

endpackage

FILE: hdl/lzd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Reads during a write to the same address return the old contents.
module lzd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: hdl/lzd_packer.sv
// Packs decoded bytes into result items of up to LANES bytes and holds the output register.
// Depends on lzd_pkg for the command and status structs.
module lzd_packer #(
   parameter int LANES = lzd_pkg::LANES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lzd_pkg::lzd_pack_req_type pk_req,
   output lzd_pkg::lzd_pack_st_type  pk_st,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_lane0,
   output logic [7:0]               rsp_lane1,
   output logic [7:0]               rsp_lane2,
   output logic [7:0]               rsp_lane3,
   output logic [7:0]               rsp_lane4,
   output logic [7:0]               rsp_lane5,
   output logic [7:0]               rsp_lane6,
   output logic [7:0]               rsp_lane7,
   output logic [3:0]               rsp_byte_count,
   output logic                     rsp_last_of_item
);
   import lzd_pkg::*;

   localparam int CW = $clog2(LANES + 1);

   logic [7:0]    pack_ff [LANES];
   logic [CW-1:0] cnt_ff;
   logic          out_vld_ff;
   logic [7:0]    lane_ff [LANE_PORTS];
   logic [3:0]    count_ff;
   logic          last_ff;
   logic [7:0]    wide [LANE_PORTS];
   logic          full;
   logic          out_free;
   logic          load;

   assign full     = (cnt_ff == CW'(LANES));
   assign out_free = !out_vld_ff || !rsp_stall;
   // Move the pack out when a byte arrives at a full pack or the item closes.
   assign load     = (pk_req.push && full) || pk_req.flush;

   assign pk_st.can_push = !full || out_free;
   assign pk_st.out_free = out_free;
   assign pk_st.empty    = (cnt_ff == '0);

   always_comb begin
      for (int i = 0; i < LANE_PORTS; i++) begin
         wide[i] = 8'd0;
      end
      for (int i = 0; i < LANES; i++) begin
         if (CW'(i) < cnt_ff) begin
            wide[i] = pack_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         if (load) begin
            out_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_vld_ff <= 1'b0;
         end
         if (pk_req.flush) begin
            cnt_ff <= '0;
         end else if (pk_req.push) begin
            cnt_ff <= full ? CW'(1) : cnt_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < LANE_PORTS; i++) begin
            lane_ff[i] <= wide[i];
         end
         count_ff <= 4'(cnt_ff);
         last_ff  <= pk_req.flush;
      end
      if (pk_req.push) begin
         if (full) begin
            pack_ff[0] <= pk_req.data;
         end else begin
            for (int i = 0; i < LANES; i++) begin
               if (CW'(i) == cnt_ff) begin
                  pack_ff[i] <= pk_req.data;
               end
            end
         end
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_lane0        = lane_ff[0];
   assign rsp_lane1        = lane_ff[1];
   assign rsp_lane2        = lane_ff[2];
   assign rsp_lane3        = lane_ff[3];
   assign rsp_lane4        = lane_ff[4];
   assign rsp_lane5        = lane_ff[5];
   assign rsp_lane6        = lane_ff[6];
   assign rsp_lane7        = lane_ff[7];
   assign rsp_byte_count   = count_ff;
   assign rsp_last_of_item = last_ff;

endmodule

FILE: hdl/lz77_token_stream_decompressor_unit.sv
// Top level of the LZ77 token stream decompressor: bit buffer, token sequencer,
// match copy pipeline over the history RAM. Uses lzd_pkg, lzd_ram, lzd_packer.
//
//  channel | ports                                    | direction
//  --------+------------------------------------------+----------
//  req     | req_valid, req_stall, req_in_byte        | in
//  rsp     | rsp_valid, rsp_stall, rsp_lane0..7,      | out
//          | rsp_byte_count, rsp_last_of_item         |
//
// An item is accepted in the idle state; the sequencer then decodes literals and
// headers in turn, copies each match byte by byte and drains the RAM read pipeline,
// and flushes the pack once it finds no complete token. The copy loop is bound by
// the single RAM read port, one byte per cycle while the packer can take a byte.
// Reset is synchronous; the window RAM is not swept: a fill flag and the write
// position mark which slots were written, and unwritten slots read as zero.
// A stalled result holds the sequencer once the pack is full or the item closes.
module lz77_token_stream_decompressor_unit #(
   parameter int WINDOW_DEPTH = lzd_pkg::WINDOW_DEPTH_DEF,
   parameter int LANES        = lzd_pkg::LANES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_lane0,
   output logic [7:0] rsp_lane1,
   output logic [7:0] rsp_lane2,
   output logic [7:0] rsp_lane3,
   output logic [7:0] rsp_lane4,
   output logic [7:0] rsp_lane5,
   output logic [7:0] rsp_lane6,
   output logic [7:0] rsp_lane7,
   output logic [3:0] rsp_byte_count,
   output logic       rsp_last_of_item
);
   import lzd_pkg::*;

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int PW = AW + 1;

   lzd_state_type    state_ff, state_in;
   logic [31:0]      buf_ff;
   logic [5:0]       bits_ff;
   logic [5:0]       lits_ff;
   logic [AW-1:0]    wpos_ff;
   logic             wrapped_ff;
   logic [8:0]       rem_ff;
   logic [AW-1:0]    rp_ff;
   logic             b_vld_ff;
   logic             fwd_ff;
   logic [7:0]       fwd_data_ff;
   logic             ok_ff;

   logic             accept;
   logic             tok_lit, tok_hdr, tok_mat, tok_none, lit_due;
   logic             wr_en;
   logic [7:0]       wr_data;
   logic             adv, issue, b_push;
   logic [7:0]       ram_q, b_byte;
   logic [15:0]      distance;
   logic [PW-1:0]    dist_m, src_w;
   lzd_pack_req_type pk_req;
   lzd_pack_st_type  pk_st;

   assign accept = req_valid && !req_stall;

   // Token decode from the head of the bit buffer.
   always_comb begin
      lit_due  = (lits_ff != 6'd0);
      tok_lit  = lit_due && (bits_ff >= 6'd8);
      tok_hdr  = !lit_due && !buf_ff[0] && (bits_ff >= 6'(1 + RUN_BITS));
      tok_mat  = !lit_due && buf_ff[0] && (bits_ff >= 6'(MATCH_TOKEN_BITS));
      tok_none = !(tok_lit || tok_hdr || tok_mat);
   end

   // Match source: write position minus distance, modulo the window depth.
   always_comb begin
      distance = {1'b0, buf_ff[9 +: DIST_BITS]} + 16'd1;
      dist_m   = (PW'(distance) == PW'(WINDOW_DEPTH)) ? '0 : PW'(distance);
      if ({1'b0, wpos_ff} >= dist_m) begin
         src_w = {1'b0, wpos_ff} - dist_m;
      end else begin
         src_w = {1'b0, wpos_ff} + PW'(WINDOW_DEPTH) - dist_m;
      end
   end

   // Copy pipeline: read issue stage, then a byte stage that pushes and writes.
   assign adv    = !b_vld_ff || pk_st.can_push;
   assign issue  = (state_ff == ST_COPY) && (rem_ff != 9'd0) && adv;
   assign b_push = (state_ff == ST_COPY) && b_vld_ff && pk_st.can_push;
   assign b_byte = fwd_ff ? fwd_data_ff : (ok_ff ? ram_q : 8'd0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (tok_mat) state_in = ST_COPY;
            else if (tok_none) state_in = ST_FLUSH;
         end
         ST_COPY: begin
            if (rem_ff == 9'd0 && !b_vld_ff) state_in = ST_DECODE;
         end
         ST_FLUSH: begin
            if (pk_st.empty || pk_st.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_stall    = 1'b1;
      pk_req.push  = 1'b0;
      pk_req.flush = 1'b0;
      pk_req.data  = buf_ff[7:0];
      wr_en        = 1'b0;
      wr_data      = buf_ff[7:0];
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_DECODE: begin
            pk_req.push = tok_lit && pk_st.can_push;
            wr_en       = tok_lit && pk_st.can_push;
         end
         ST_COPY: begin
            pk_req.push = b_push;
            pk_req.data = b_byte;
            wr_en       = b_push;
            wr_data     = b_byte;
         end
         ST_FLUSH: begin
            pk_req.flush = !pk_st.empty && pk_st.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         buf_ff     <= '0;
         bits_ff    <= '0;
         lits_ff    <= '0;
         wpos_ff    <= '0;
         wrapped_ff <= 1'b0;
         rem_ff     <= '0;
         b_vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         // Append the item LSB-first behind the held bits.
         if (accept && bits_ff <= 6'd24) begin
            buf_ff  <= buf_ff | (32'(req_in_byte) << bits_ff);
            bits_ff <= bits_ff + 6'd8;
         end
         if (state_ff == ST_DECODE) begin
            if (tok_lit && pk_st.can_push) begin
               buf_ff  <= buf_ff >> 8;
               bits_ff <= bits_ff - 6'd8;
               lits_ff <= lits_ff - 6'd1;
            end else if (tok_hdr) begin
               buf_ff  <= buf_ff >> (1 + RUN_BITS);
               bits_ff <= bits_ff - 6'(1 + RUN_BITS);
               lits_ff <= 6'(buf_ff[1 +: RUN_BITS]) + 6'd1;
            end else if (tok_mat) begin
               buf_ff  <= buf_ff >> MATCH_TOKEN_BITS;
               bits_ff <= bits_ff - 6'(MATCH_TOKEN_BITS);
               rem_ff  <= 9'(buf_ff[8:1]) + 9'(MIN_MATCH);
            end
         end
         if (issue) begin
            rem_ff <= rem_ff - 9'd1;
         end
         if (state_ff == ST_COPY && adv) begin
            b_vld_ff <= issue;
         end
         if (wr_en) begin
            if (wpos_ff == AW'(WINDOW_DEPTH - 1)) begin
               wpos_ff    <= '0;
               wrapped_ff <= 1'b1;
            end else begin
               wpos_ff <= wpos_ff + AW'(1);
            end
         end
      end
   end

   // Read pointer and forwarding of a byte written while its slot is read.
   always_ff @(posedge clock) begin
      if (state_ff == ST_DECODE && tok_mat) begin
         rp_ff <= AW'(src_w);
      end else if (issue) begin
         rp_ff <= (rp_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : rp_ff + AW'(1);
      end
      if (issue) begin
         fwd_ff      <= wr_en && (rp_ff == wpos_ff);
         fwd_data_ff <= wr_data;
         ok_ff       <= wrapped_ff || (rp_ff < wpos_ff);
      end
   end

   lzd_ram #(
      .WIDTH (8),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wpos_ff),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (rp_ff),
      .rd_data (ram_q)
   );

   lzd_packer #(
      .LANES (LANES)
   ) u_packer (
      .clock            (clock),
      .reset            (reset),
      .pk_req           (pk_req),
      .pk_st            (pk_st),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_lane0        (rsp_lane0),
      .rsp_lane1        (rsp_lane1),
      .rsp_lane2        (rsp_lane2),
      .rsp_lane3        (rsp_lane3),
      .rsp_lane4        (rsp_lane4),
      .rsp_lane5        (rsp_lane5),
      .rsp_lane6        (rsp_lane6),
      .rsp_lane7        (rsp_lane7),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_last_of_item (rsp_last_of_item)
   );

`ifndef ASSERT_OFF
   a_bits_bound: assert property (@(posedge clock) disable iff (reset)
      bits_ff <= 6'd31)
      else $error("bit buffer overfilled");
   a_wr_advances: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (wpos_ff != $past(wpos_ff)))
      else $error("write position did not advance");
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!b_vld_ff && rem_ff == 9'd0 && pk_st.empty))
      else $error("idle with copy or pack pending");
`endif

endmodule

FILE: tb/lz77_token_stream_decompressor_unit_check.sv
// Checker for the LZ77 token stream decompressor: watches both channels, predicts.
// Holds its own bit buffer and history window; depends on nothing but the ports.
module lz77_token_stream_decompressor_unit_check (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_lane0,
   input  logic [7:0] rsp_lane1,
   input  logic [7:0] rsp_lane2,
   input  logic [7:0] rsp_lane3,
   input  logic [7:0] rsp_lane4,
   input  logic [7:0] rsp_lane5,
   input  logic [7:0] rsp_lane6,
   input  logic [7:0] rsp_lane7,
   input  logic [3:0] rsp_byte_count,
   input  logic       rsp_last_of_item,
   output int         fail_count,
   output int         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIN = 32768;

   typedef struct packed {
      logic [7:0][7:0] lanes;
      logic [3:0]      count;
      logic            last;
   } out_pack_t;

   out_pack_t   pack_q[$];
   logic [31:0] bitbuf;
   int unsigned nbits;
   int unsigned lits_left;
   logic [7:0]  window [WIN];
   logic [14:0] wpos;
   logic [7:0]  decoded[$];

   function automatic void emit(logic [7:0] b);
      window[wpos] = b;
      wpos = wpos + 15'd1;
      decoded.push_back(b);
   endfunction

   function automatic void decode_byte(logic [7:0] b);
      int unsigned len, distance;
      int          nres, cnt;
      out_pack_t   p;
      logic [14:0] src;
      decoded.delete();
      if (nbits <= 24) begin
         bitbuf = bitbuf | (32'(b) << nbits);
         nbits += 8;
      end
      forever begin
         if (lits_left != 0) begin
            if (nbits < 8) break;
            emit(bitbuf[7:0]);
            bitbuf = bitbuf >> 8; nbits -= 8;
            lits_left--;
         end else if (nbits < 1) begin
            break;
         end else if (!bitbuf[0]) begin
            if (nbits < 6) break;
            lits_left = bitbuf[5:1] + 1;
            bitbuf = bitbuf >> 6; nbits -= 6;
         end else begin
            if (nbits < 24) break;
            len      = bitbuf[8:1] + 3;
            distance = bitbuf[23:9] + 1;
            bitbuf = bitbuf >> 24; nbits -= 24;
            for (int k = 0; k < len; k++) begin
               src = wpos - 15'(distance % WIN);
               emit(window[src]);
            end
         end
      end
      nres = (decoded.size() + 7) / 8;
      for (int r = 0; r < nres; r++) begin
         cnt = decoded.size() - r * 8;
         if (cnt > 8) cnt = 8;
         p = '0;
         for (int i = 0; i < cnt; i++) p.lanes[i] = decoded[r * 8 + i];
         p.count = 4'(cnt);
         p.last  = (r + 1 == nres);
         pack_q.push_back(p);
      end
   endfunction

   always @(posedge clock) begin
      out_pack_t want, got;
      if (reset) begin
         bitbuf = '0; nbits = 0; lits_left = 0; wpos = '0;
         for (int i = 0; i < WIN; i++) window[i] = 8'h00;
         pack_q.delete();
         fail_count = 0;
      end else begin
         if (req_valid && !req_stall) decode_byte(req_in_byte);
         if (rsp_valid && !rsp_stall) begin
            got.lanes = {rsp_lane7, rsp_lane6, rsp_lane5, rsp_lane4,
                         rsp_lane3, rsp_lane2, rsp_lane1, rsp_lane0};
            got.count = rsp_byte_count;
            got.last  = rsp_last_of_item;
            if (pack_q.size() == 0) begin
               $display("%0t: unexpected result, expected none actual %h", $realtime, got);
               fail_count++;
            end else begin
               want = pack_q.pop_front();
               for (int i = 0; i < 8; i++)
                  if (want.lanes[i] !== got.lanes[i]) begin
                     $display("%0t: lane%0d expected %h actual %h", $realtime, i,
                              want.lanes[i], got.lanes[i]);
                     fail_count++;
                  end
               if (want.count !== got.count) begin
                  $display("%0t: byte_count expected %0d actual %0d", $realtime,
                           want.count, got.count);
                  fail_count++;
               end
               if (want.last !== got.last) begin
                  $display("%0t: last_of_item expected %b actual %b", $realtime,
                           want.last, got.last);
                  fail_count++;
               end
            end
         end
      end
      pending_count = pack_q.size();
   end
endmodule

FILE: tb/lz77_token_stream_decompressor_unit_test.sv
// Stimulus and verdict for the LZ77 token stream decompressor.
// Drives token streams into the unit; checking is done by the _check module.
module lz77_token_stream_decompressor_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_lane0, rsp_lane1, rsp_lane2, rsp_lane3;
   logic [7:0] rsp_lane4, rsp_lane5, rsp_lane6, rsp_lane7;
   logic [3:0] rsp_byte_count;
   logic       rsp_last_of_item;
   int         fail_count, pending_count;
   int         cycle_count = 0;

   localparam int CYCLE_LIMIT = 600000;

   bit         token_bits[$];
   logic [7:0] stream_q[$];

   lz77_token_stream_decompressor_unit uut (.*);
   lz77_token_stream_decompressor_unit_check check (.*);

   // Clock: 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Quiet stretch: no idling on either side between these cycles.
   function automatic bit idle_now();
      if (cycle_count > 3000 && cycle_count < 9000) return 1'b0;
      return $urandom_range(99) < 28;
   endfunction

   // Receiver stall, random except during the quiet stretch.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_stall   <= reset ? 1'b0 : idle_now();
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("lz77_token_stream_decompressor_unit test failed");
         $finish;
      end
   end

   // Append n bits of v to the token stream, LSB first.
   function automatic void put_bits(int unsigned v, int n);
      for (int i = 0; i < n; i++) token_bits.push_back(v[i]);
   endfunction

   function automatic void literal_run(int n, int mode);
      put_bits(0, 1);
      put_bits(n - 1, 5);
      for (int i = 0; i < n; i++)
         put_bits(mode == 0 ? 8'h00 : mode == 1 ? 8'hFF : $urandom_range(255), 8);
   endfunction

   function automatic void match_token(int len, int distance);
      put_bits(1, 1);
      put_bits(len - 3, 8);
      put_bits(distance - 1, 15);
   endfunction

   // Pack the pending bits into bytes; hold back an incomplete tail.
   function automatic void pack_bits();
      logic [7:0] b;
      while (token_bits.size() >= 8) begin
         for (int i = 0; i < 8; i++) b[i] = token_bits.pop_front();
         stream_q.push_back(b);
      end
   endfunction

   // Present one item and hold it until accepted.
   task automatic send_item(logic [7:0] b);
      while (idle_now()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_stream();
      pack_bits();
      while (stream_q.size() > 0) send_item(stream_q.pop_front());
   endtask

   initial begin
      int sent;
      int pick;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: match before any byte was written (reads zeros), max distance,
      // full run of 0xFF literals, a 0x00 literal, max-length overlapping match, raw bytes.
      match_token(3, 32768);
      literal_run(32, 1);
      literal_run(1, 0);
      match_token(258, 1);
      literal_run(3, 2);
      match_token(10, 2);
      drain_stream();
      send_item(8'h00);
      send_item(8'hFF);
      send_item(8'hAA);
      send_item(8'h55);

      // Random: mostly well-formed tokens, some raw noise bits.
      sent = 0;
      while (sent < 170) begin
         pick = $urandom_range(99);
         if (pick < 40)
            literal_run($urandom_range(1, 32), 2);
         else if (pick < 60)
            match_token($urandom_range(3, 20), $urandom_range(1, 64));
         else if (pick < 72)
            match_token(258, $urandom_range(1, 32768));
         else if (pick < 85)
            match_token($urandom_range(3, 258), $urandom_range(1, 32768));
         else
            put_bits($urandom, $urandom_range(1, 16));
         pack_bits();
         sent += stream_q.size();
         drain_stream();
      end
      req_valid <= 1'b0;

      // Wait for every expected result, then let the pipeline settle.
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("lz77_token_stream_decompressor_unit test passed");
      else
         $display("lz77_token_stream_decompressor_unit test failed");
      $finish;
   end
endmodule
